[hw/rtl/fpa_pkg.sv]
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  // Width of the scaled dividend |a| << FRAC_BITS, one quotient bit per stage.
  localparam int NUM_W = 32 + FRAC_BITS;
  // Input stage, product, product rounding, divider steps, quotient rounding, saturation.
  localparam int NSTG = NUM_W + 5;
  // Stage that holds the last divider step.
  localparam int RD = NUM_W + 2;

  localparam logic [3:0] MODE_ADD = 4'd0;
  localparam logic [3:0] MODE_SUB = 4'd1;
  localparam logic [3:0] MODE_MUL = 4'd2;
  localparam logic [3:0] MODE_DIV = 4'd3;
  localparam logic [3:0] MODE_GT  = 4'd4;
  localparam logic [3:0] MODE_LT  = 4'd5;
  localparam logic [3:0] MODE_GE  = 4'd6;
  localparam logic [3:0] MODE_LE  = 4'd7;
  localparam logic [3:0] MODE_EQ  = 4'd8;
  localparam logic [3:0] MODE_NE  = 4'd9;
  localparam logic [3:0] MODE_MIN = 4'd10;
  localparam logic [3:0] MODE_MAX = 4'd11;
  localparam logic [3:0] MODE_INC = 4'd12;
  localparam logic [3:0] MODE_DEC = 4'd13;
  localparam logic [3:0] MODE_I2F = 4'd14;
  localparam logic [3:0] MODE_F2I = 4'd15;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_DIVZ = 2'd2;

  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  typedef struct packed {
    logic              valid;
    logic [3:0]        mode;
    logic              neg;
    logic              divz;
    logic [31:0]       mb;
    logic [63:0]       w;
    logic [32:0]       rem;
    logic [NUM_W-1:0]  nq;
    logic signed [31:0] value;
    logic              truth;
    logic [1:0]        status;
  } stage_t;

endpackage

[hw/rtl/fpa_cmd_if.sv]
interface fpa_cmd_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink (input valid, mode, operand_a, operand_b, output ready);
endinterface

[hw/rtl/fpa_rsp_if.sv]
interface fpa_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               truth;
  logic [1:0]         status;

  modport source (output valid, value, truth, status, input ready);
  modport sink (input valid, value, truth, status, output ready);
endinterface

[hw/rtl/fixed_point_alu_q24_8.sv]
// Fixed-point ALU on signed 32-bit raw values with fpa_pkg::FRAC_BITS fractional bits.
// One result item leaves for every command item, in order. The unit is a single
// pipeline of fpa_pkg::NSTG stages (45 at 8 fractional bits), and one item enters
// every cycle unless the pipeline stalls. The depth is set by the restoring divider,
// which retires one quotient bit per stage over the 40-bit scaled dividend. The whole
// pipeline advances together: it holds while the last stage carries a result that the
// sink has not taken. Multiply and divide round to nearest with ties away from zero;
// overflow saturates with status 1, divide by zero gives 0 with status 2.
module fixed_point_alu_q24_8 (
  input logic          clk,
  input logic          rst,
  fpa_cmd_if.sink      cmd,
  fpa_rsp_if.source    rsp
);

  fpa_pkg::stage_t pipe [fpa_pkg::NSTG];
  fpa_pkg::stage_t s0_next;
  fpa_pkg::stage_t mul_next;
  fpa_pkg::stage_t mrnd_next;
  fpa_pkg::stage_t qrnd_next;
  logic            en;

  // Advance whenever the last stage is empty or being drained.
  assign en = !pipe[fpa_pkg::NSTG-1].valid || rsp.ready;
  assign cmd.ready = en;

  // Input stage: decode, do every short operation, set up multiply and divide.
  logic signed [32:0] sum, dif;
  logic [31:0]        ma, mb;
  always_comb begin
    sum = {cmd.operand_a[31], cmd.operand_a} + {cmd.operand_b[31], cmd.operand_b};
    dif = {cmd.operand_a[31], cmd.operand_a} - {cmd.operand_b[31], cmd.operand_b};
    ma  = cmd.operand_a[31] ? 32'(-cmd.operand_a) : cmd.operand_a;
    mb  = cmd.operand_b[31] ? 32'(-cmd.operand_b) : cmd.operand_b;
    s0_next        = '0;
    s0_next.valid  = cmd.valid;
    s0_next.mode   = cmd.mode;
    s0_next.neg    = cmd.operand_a[31] ^ cmd.operand_b[31];
    s0_next.divz   = (cmd.operand_b == '0);
    s0_next.mb     = mb;
    s0_next.w      = {32'd0, ma};
    s0_next.nq     = {ma, {fpa_pkg::FRAC_BITS{1'b0}}};
    s0_next.value  = '0;
    s0_next.truth  = 1'b0;
    s0_next.status = fpa_pkg::STAT_OK;
    case (cmd.mode)
      fpa_pkg::MODE_ADD: begin
        if (sum[32] != sum[31]) begin
          s0_next.value  = sum[32] ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
          s0_next.status = fpa_pkg::STAT_SAT;
        end else begin
          s0_next.value = sum[31:0];
        end
      end
      fpa_pkg::MODE_SUB: begin
        if (dif[32] != dif[31]) begin
          s0_next.value  = dif[32] ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
          s0_next.status = fpa_pkg::STAT_SAT;
        end else begin
          s0_next.value = dif[31:0];
        end
      end
      fpa_pkg::MODE_GT: s0_next.truth = cmd.operand_a > cmd.operand_b;
      fpa_pkg::MODE_LT: s0_next.truth = cmd.operand_a < cmd.operand_b;
      fpa_pkg::MODE_GE: s0_next.truth = cmd.operand_a >= cmd.operand_b;
      fpa_pkg::MODE_LE: s0_next.truth = cmd.operand_a <= cmd.operand_b;
      fpa_pkg::MODE_EQ: s0_next.truth = cmd.operand_a == cmd.operand_b;
      fpa_pkg::MODE_NE: s0_next.truth = cmd.operand_a != cmd.operand_b;
      fpa_pkg::MODE_MIN: begin
        s0_next.value = (cmd.operand_a < cmd.operand_b) ? cmd.operand_a : cmd.operand_b;
      end
      fpa_pkg::MODE_MAX: begin
        s0_next.value = (cmd.operand_a > cmd.operand_b) ? cmd.operand_a : cmd.operand_b;
      end
      fpa_pkg::MODE_INC: begin
        if (cmd.operand_a == fpa_pkg::MAX32) begin
          s0_next.value  = fpa_pkg::MAX32;
          s0_next.status = fpa_pkg::STAT_SAT;
        end else begin
          s0_next.value = cmd.operand_a + 32'sd1;
        end
      end
      fpa_pkg::MODE_DEC: begin
        if (cmd.operand_a == fpa_pkg::MIN32) begin
          s0_next.value  = fpa_pkg::MIN32;
          s0_next.status = fpa_pkg::STAT_SAT;
        end else begin
          s0_next.value = cmd.operand_a - 32'sd1;
        end
      end
      fpa_pkg::MODE_I2F: begin
        // Saturate when the shift would push bits past the sign.
        if (cmd.operand_a > (fpa_pkg::MAX32 >>> fpa_pkg::FRAC_BITS)) begin
          s0_next.value  = fpa_pkg::MAX32;
          s0_next.status = fpa_pkg::STAT_SAT;
        end else if (cmd.operand_a < (fpa_pkg::MIN32 >>> fpa_pkg::FRAC_BITS)) begin
          s0_next.value  = fpa_pkg::MIN32;
          s0_next.status = fpa_pkg::STAT_SAT;
        end else begin
          s0_next.value = cmd.operand_a <<< fpa_pkg::FRAC_BITS;
        end
      end
      fpa_pkg::MODE_F2I: s0_next.value = cmd.operand_a >>> fpa_pkg::FRAC_BITS;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (en) begin
      pipe[0] <= s0_next;
    end
  end

  // Multiplier: magnitude product, registered.
  always_comb begin
    mul_next = pipe[0];
    if (pipe[0].mode == fpa_pkg::MODE_MUL) begin
      mul_next.w = 64'(pipe[0].w[31:0]) * 64'(pipe[0].mb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[1].valid <= 1'b0;
    end else if (en) begin
      pipe[1] <= mul_next;
    end
  end

  // Round the product to nearest, ties away from zero on the magnitude.
  always_comb begin
    mrnd_next = pipe[1];
    if (pipe[1].mode == fpa_pkg::MODE_MUL) begin
      mrnd_next.w = (pipe[1].w + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[2].valid <= 1'b0;
    end else if (en) begin
      pipe[2] <= mrnd_next;
    end
  end

  // Restoring divider: one quotient bit per stage.
  for (genvar j = 0; j < fpa_pkg::NUM_W; j++) begin : g_div
    logic [32:0]     rem_sh;
    logic            ge;
    fpa_pkg::stage_t div_next;
    always_comb begin
      rem_sh       = {pipe[2+j].rem[31:0], pipe[2+j].nq[fpa_pkg::NUM_W-1]};
      ge           = rem_sh >= {1'b0, pipe[2+j].mb};
      div_next     = pipe[2+j];
      div_next.rem = ge ? rem_sh - {1'b0, pipe[2+j].mb} : rem_sh;
      div_next.nq  = {pipe[2+j].nq[fpa_pkg::NUM_W-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[3+j].valid <= 1'b0;
      end else if (en) begin
        pipe[3+j] <= div_next;
      end
    end
  end

  // Round the quotient: add one when twice the remainder reaches the divisor.
  always_comb begin
    qrnd_next = pipe[fpa_pkg::RD];
    if (pipe[fpa_pkg::RD].mode == fpa_pkg::MODE_DIV) begin
      qrnd_next.w = 64'(pipe[fpa_pkg::RD].nq)
                  + 64'({pipe[fpa_pkg::RD].rem, 1'b0} >= {2'b0, pipe[fpa_pkg::RD].mb});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[fpa_pkg::RD+1].valid <= 1'b0;
    end else if (en) begin
      pipe[fpa_pkg::RD+1] <= qrnd_next;
    end
  end

  // Apply the sign and saturate multiply and divide results; flag divide by zero.
  fpa_pkg::stage_t fin;
  always_comb begin
    fin = pipe[fpa_pkg::RD+1];
    if (fin.mode == fpa_pkg::MODE_MUL || fin.mode == fpa_pkg::MODE_DIV) begin
      fin.status = fpa_pkg::STAT_OK;
      if (fin.mode == fpa_pkg::MODE_DIV && fin.divz) begin
        fin.value  = '0;
        fin.status = fpa_pkg::STAT_DIVZ;
      end else if (fin.neg && fin.w != '0) begin
        if (fin.w > 64'h8000_0000) begin
          fin.value  = fpa_pkg::MIN32;
          fin.status = fpa_pkg::STAT_SAT;
        end else begin
          fin.value = 32'(-fin.w);
        end
      end else if (fin.w > 64'h7fff_ffff) begin
        fin.value  = fpa_pkg::MAX32;
        fin.status = fpa_pkg::STAT_SAT;
      end else begin
        fin.value = fin.w[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[fpa_pkg::RD+2].valid <= 1'b0;
    end else if (en) begin
      pipe[fpa_pkg::RD+2] <= fin;
    end
  end

  assign rsp.valid  = pipe[fpa_pkg::NSTG-1].valid;
  assign rsp.value  = pipe[fpa_pkg::NSTG-1].value;
  assign rsp.truth  = pipe[fpa_pkg::NSTG-1].truth;
  assign rsp.status = pipe[fpa_pkg::NSTG-1].status;

  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == fpa_pkg::STAT_DIVZ |-> rsp.value == '0)
    else $error("division by zero with nonzero value");

  a_truth_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.truth |-> rsp.value == '0 && rsp.status == fpa_pkg::STAT_OK)
    else $error("comparison result carries value or status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status != 2'd3)
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pipe[fpa_pkg::NSTG-1]))
    else $error("last stage changed during stall");

endmodule

[tb/sv/tb_fixed_point_alu_q24_8.sv]
module tb_fixed_point_alu_q24_8;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpa_cmd_if cmd();
  fpa_rsp_if rsp();

  fixed_point_alu_q24_8 u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd.sink),
    .rsp(rsp.source)
  );

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_op_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               truth;
    logic [1:0]         status;
  } alu_res_t;

  alu_op_t  op_q[$];
  alu_res_t res_q[$];
  int mismatch_cnt = 0;
  int send_idle_pct = 15;
  int recv_idle_pct = 81;
  bit stim_done = 1'b0;

  // Saturate a wide signed value to 32 bits, flag overflow.
  function automatic void sat32(input logic signed [95:0] v,
                                output logic signed [31:0] r, inout logic [1:0] st);
    if (v > 96'sh7fff_ffff) begin
      r = fpa_pkg::MAX32;
      st = fpa_pkg::STAT_SAT;
    end else if (v < -96'sh8000_0000) begin
      r = fpa_pkg::MIN32;
      st = fpa_pkg::STAT_SAT;
    end else begin
      r = v[31:0];
    end
  endfunction

  // Compute the expected result of one ALU item with exact integer math.
  function automatic alu_res_t alu_predict(input alu_op_t op);
    alu_res_t r;
    logic signed [95:0] sa, sb, t;
    logic [95:0] ma, mb, m;
    logic neg;
    sa = op.a;
    sb = op.b;
    ma = (sa < 0) ? -sa : sa;
    mb = (sb < 0) ? -sb : sb;
    r = '0;
    neg = (sa < 0) != (sb < 0);
    case (op.mode)
      fpa_pkg::MODE_ADD: sat32(sa + sb, r.value, r.status);
      fpa_pkg::MODE_SUB: sat32(sa - sb, r.value, r.status);
      fpa_pkg::MODE_MUL: begin
        m = (ma * mb + (96'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
        t = (neg && m != 0) ? -$signed(m) : $signed(m);
        sat32(t, r.value, r.status);
      end
      fpa_pkg::MODE_DIV: begin
        if (sb == 0) begin
          r.status = fpa_pkg::STAT_DIVZ;
        end else begin
          m = (2 * (ma << fpa_pkg::FRAC_BITS) + mb) / (2 * mb);
          t = (neg && m != 0) ? -$signed(m) : $signed(m);
          sat32(t, r.value, r.status);
        end
      end
      fpa_pkg::MODE_GT: r.truth = sa > sb;
      fpa_pkg::MODE_LT: r.truth = sa < sb;
      fpa_pkg::MODE_GE: r.truth = sa >= sb;
      fpa_pkg::MODE_LE: r.truth = sa <= sb;
      fpa_pkg::MODE_EQ: r.truth = sa == sb;
      fpa_pkg::MODE_NE: r.truth = sa != sb;
      fpa_pkg::MODE_MIN: r.value = (sa < sb) ? op.a : op.b;
      fpa_pkg::MODE_MAX: r.value = (sa > sb) ? op.a : op.b;
      fpa_pkg::MODE_INC: sat32(sa + 1, r.value, r.status);
      fpa_pkg::MODE_DEC: sat32(sa - 1, r.value, r.status);
      fpa_pkg::MODE_I2F: sat32(sa * (96'sd1 << fpa_pkg::FRAC_BITS), r.value, r.status);
      default: r.value = op.a >>> fpa_pkg::FRAC_BITS;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return fpa_pkg::MAX32 - $urandom_range(0, 3);
      1: return fpa_pkg::MIN32 + $urandom_range(0, 3);
      2: return $urandom_range(0, 2047) - 1024;
      3: return $urandom_range(0, 1 << 20) - (1 << 19);
      4: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(input logic [3:0] mode, input logic [31:0] a, input logic [31:0] b);
    op_q.push_back('{mode, a, b});
  endtask

  task automatic wait_drain();
    while (op_q.size() != 0 || cmd.valid || res_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: present the head of the pending queue, random gaps.
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      cmd.mode <= '0;
      cmd.operand_a <= '0;
      cmd.operand_b <= '0;
    end else if (!cmd.valid || cmd.ready) begin
      if (cmd.valid) begin
        // Item accepted at this edge; log what the ALU must return.
        res_q.push_back(alu_predict('{cmd.mode, cmd.operand_a, cmd.operand_b}));
      end
      if (op_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        alu_op_t op;
        op = op_q.pop_front();
        cmd.valid <= 1'b1;
        cmd.mode <= op.mode;
        cmd.operand_a <= op.a;
        cmd.operand_b <= op.b;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (res_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result value=%h truth=%b status=%0d",
                     rsp.value, rsp.truth, rsp.status);
        end else begin
          alu_res_t exp_r;
          exp_r = res_q.pop_front();
          if (exp_r.value !== rsp.value || exp_r.truth !== rsp.truth ||
              exp_r.status !== rsp.status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"mismatch exp value=%h truth=%b status=%0d",
                        " got value=%h truth=%b status=%0d"},
                       exp_r.value, exp_r.truth, exp_r.status,
                       rsp.value, rsp.truth, rsp.status);
          end
        end
      end
      rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Stimulus.
  initial begin
    logic [31:0] ext[8];
    ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1, 32'hffff_ffff,
            32'h100, 32'hffff_ff00, 32'h80};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: every mode at extremes, plus tie rounding and divide by zero.
    for (int m = 0; m < 16; m++) queue_op(m[3:0], ext[m % 8], ext[(m + 3) % 8]);
    queue_op(fpa_pkg::MODE_MUL, 32'h180, 32'h1);        // tie 1.5 LSB rounds away
    queue_op(fpa_pkg::MODE_MUL, 32'hffff_fe80, 32'h1);  // negative tie
    queue_op(fpa_pkg::MODE_DIV, 32'h100, 32'h0);        // divide by zero
    queue_op(fpa_pkg::MODE_DIV, 32'h8000_0000, 32'h80); // saturates
    queue_op(fpa_pkg::MODE_DIV, 32'h1, 32'h200);        // exact half rounds up
    queue_op(fpa_pkg::MODE_MIN, 32'h55, 32'h55);
    queue_op(fpa_pkg::MODE_MAX, 32'h8000_0000, 32'h8000_0000);
    queue_op(fpa_pkg::MODE_I2F, 32'hff80_0000, 32'h0);  // exactly the minimum
    wait_drain();

    // Random, three idling phases; one full drain pause in the middle.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 81 : 0;
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 15 : 0;
      for (int i = 0; i < 380; i++) begin
        queue_op(4'($urandom_range(0, 15)), rand_operand(), rand_operand());
        if (ph == 1 && i == 190) begin
          // Hold new items back until every pending result has come.
          wait_drain();
        end
      end
      wait_drain();
    end
    repeat (60) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (mismatch_cnt == 0 && res_q.size() == 0) begin
      $display("fixed_point_alu_q24_8 regression: pass");
    end else begin
      $display("fixed_point_alu_q24_8 regression: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #(2_000_000ns);
    $display("fixed_point_alu_q24_8 regression: fail");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_cmd_if.sv
hw/rtl/fpa_rsp_if.sv
hw/rtl/fixed_point_alu_q24_8.sv
tb/sv/tb_fixed_point_alu_q24_8.sv
